[sv/ntt4_pkg.sv]
// Shared types, widths and modular add/subtract helpers for the radix-4 NTT butterfly.
// No dependencies.
package ntt4_pkg;

  localparam int RES_W = 50;
  localparam int CNT_W = 3;
  localparam logic [RES_W-1:0] MODULUS_RST = 50'd1108307720798209;
  localparam logic [CNT_W-1:0] CNT_MAX = 3'd4;
  localparam logic [CNT_W-1:0] CNT_R2 = 3'd2;
  localparam logic OP_RADIX2 = 1'b0;
  localparam logic OP_RADIX4 = 1'b1;

  typedef struct packed {
    logic             op;
    logic [RES_W-1:0] a0;
    logic [RES_W-1:0] a1;
    logic [RES_W-1:0] a2;
    logic [RES_W-1:0] a3;
    logic [RES_W-1:0] tw_main;
    logic [RES_W-1:0] tw_square;
    logic [RES_W-1:0] tw_imag;
    logic [CNT_W-1:0] in_count;
    logic [CNT_W-1:0] out_count;
  } ntt4_in_t;

  typedef struct packed {
    logic [RES_W-1:0] b0;
    logic [RES_W-1:0] b1;
    logic [RES_W-1:0] b2;
    logic [RES_W-1:0] b3;
    logic [CNT_W-1:0] valid_count;
  } ntt4_out_t;

  // Both operands are below m.
  function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                                input logic [RES_W-1:0] b,
                                                input logic [RES_W-1:0] m);
    logic [RES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] a,
                                                input logic [RES_W-1:0] b,
                                                input logic [RES_W-1:0] m);
    logic [RES_W-1:0] d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = a + (m - b);
    end
    return d;
  endfunction

endpackage

[sv/ntt4_mulmod.sv]
// Pipelined shift-and-add modular product, one multiplier bit per register stage.
// Carries a sideband word alongside the product. Does not use ntt4_pkg.
module ntt4_mulmod #(
  parameter int W      = 50,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [W-1:0]      m,
  input  logic              in_vld,
  input  logic [W-1:0]      in_a,
  input  logic [W-1:0]      in_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [W-1:0]      out_p,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r  [W];
  logic [W-1:0]      acc_r  [W];
  logic [W-1:0]      a_r    [W];
  logic [W-1:0]      b_r    [W];
  logic [SIDE_W-1:0] side_r [W];

  // acc = 2*acc + bit*a, which stays below 3m, then one of two subtractions.
  function automatic logic [W-1:0] step(input logic [W-1:0] acc, input logic [W-1:0] a,
                                        input logic bit_in, input logic [W-1:0] mm);
    logic [W+1:0] t;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    t  = {1'b0, acc, 1'b0} + (bit_in ? {2'b00, a} : {(W+2){1'b0}});
    m1 = {2'b00, mm};
    m2 = {1'b0, mm, 1'b0};
    if (t >= m2) begin
      t = t - m2;
    end else if (t >= m1) begin
      t = t - m1;
    end
    return t[W-1:0];
  endfunction

  for (genvar i = 0; i < W; i++) begin : g_st
    logic              vld_src;
    logic [W-1:0]      acc_src;
    logic [W-1:0]      a_src;
    logic [W-1:0]      b_src;
    logic [SIDE_W-1:0] side_src;

    if (i == 0) begin : g_first
      assign vld_src  = in_vld;
      assign acc_src  = '0;
      assign a_src    = in_a;
      assign b_src    = in_b;
      assign side_src = in_side;
    end else begin : g_next
      assign vld_src  = vld_r[i-1];
      assign acc_src  = acc_r[i-1];
      assign a_src    = a_r[i-1];
      assign b_src    = b_r[i-1];
      assign side_src = side_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      acc_r[i]  <= step(acc_src, a_src, b_src[W-1], m);
      a_r[i]    <= a_src;
      b_r[i]    <= {b_src[W-2:0], 1'b0};
      side_r[i] <= side_src;
    end
  end

  assign out_vld  = vld_r[W-1];
  assign out_p    = acc_r[W-1];
  assign out_side = side_r[W-1];

endmodule

[sv/ntt_radix4_butterfly_unit.sv]
// Top level of the modular radix-4/radix-2 NTT butterfly.
// Depends on ntt4_pkg and ntt4_mulmod.
//
// Usage: raise start with a request on in_data; it is taken at any edge where
// start is high, as busy is always low. One request may be issued every cycle.
// Each request gives one result on out_data, marked by out_strobe for one
// cycle, in order. A request passes through three chained bit-serial product
// pipelines of RES_W stages each (operand reduction, the w^2 products and the
// w / iw products) and then two add/subtract stages, the pair sums and the
// final butterfly. Throughput is one butterfly per cycle.
// The modulus is written through cfg_we/cfg_wdata and should be changed only
// when no request is in flight. Reset clears the pipeline valid bits and
// restores the default modulus; requests in flight are dropped.
// Results cannot be held off: out_strobe must be sampled when it occurs.
module ntt_radix4_butterfly_unit
  import ntt4_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ntt4_in_t         in_data,
  output logic             out_strobe,
  output ntt4_out_t        out_data,
  input  logic             cfg_we,
  input  logic [RES_W-1:0] cfg_wdata
);

  localparam int W   = RES_W;
  localparam int LAT = 3 * W + 2;
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};

  logic [W-1:0] modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // Input masking and result count.
  logic [CNT_W-1:0] icnt;
  logic [CNT_W-1:0] vc;
  logic [CNT_W-1:0] lim;
  logic [W-1:0]     a0m, a1m, a2m, a3m;
  logic             req;

  always_comb begin
    icnt = (in_data.in_count > CNT_MAX) ? CNT_MAX : in_data.in_count;
    lim  = (in_data.op == OP_RADIX4) ? CNT_MAX : CNT_R2;
    vc   = (in_data.out_count > lim) ? lim : in_data.out_count;
    a0m  = (icnt > 3'd0) ? in_data.a0 : '0;
    a1m  = (icnt > 3'd1) ? in_data.a1 : '0;
    // In radix-2 the upper pair is zeroed so the same datapath yields a0 +- w*a1.
    a2m  = (icnt > 3'd2 && in_data.op == OP_RADIX4) ? in_data.a2 : '0;
    a3m  = (icnt > 3'd3 && in_data.op == OP_RADIX4) ? in_data.a3 : '0;
    req  = start && !busy;
  end

  // Reduction of the operands that feed additions or act as multiplicands.
  localparam int SA_W = 2 * W + CNT_W;
  logic            va;
  logic [W-1:0]    a0r, a1r, wr, w2r, iwr;
  logic [SA_W-1:0] side_a;

  ntt4_mulmod #(.W(W), .SIDE_W(SA_W)) u_red_a0 (
    .clk, .rst_n, .m(modulus_r), .in_vld(req), .in_a(ONE), .in_b(a0m),
    .in_side({vc, a2m, a3m}), .out_vld(va), .out_p(a0r), .out_side(side_a));
  ntt4_mulmod #(.W(W), .SIDE_W(1)) u_red_a1 (
    .clk, .rst_n, .m(modulus_r), .in_vld(req), .in_a(ONE), .in_b(a1m),
    .in_side(1'b0), .out_vld(), .out_p(a1r), .out_side());
  ntt4_mulmod #(.W(W), .SIDE_W(1)) u_red_w (
    .clk, .rst_n, .m(modulus_r), .in_vld(req), .in_a(ONE), .in_b(in_data.tw_main),
    .in_side(1'b0), .out_vld(), .out_p(wr), .out_side());
  ntt4_mulmod #(.W(W), .SIDE_W(1)) u_red_w2 (
    .clk, .rst_n, .m(modulus_r), .in_vld(req), .in_a(ONE), .in_b(in_data.tw_square),
    .in_side(1'b0), .out_vld(), .out_p(w2r), .out_side());
  ntt4_mulmod #(.W(W), .SIDE_W(1)) u_red_iw (
    .clk, .rst_n, .m(modulus_r), .in_vld(req), .in_a(ONE), .in_b(in_data.tw_imag),
    .in_side(1'b0), .out_vld(), .out_p(iwr), .out_side());

  // w^2 * a2 and w^2 * a3.
  localparam int SB_W = 4 * W + CNT_W;
  logic            vb;
  logic [W-1:0]    x2, x3;
  logic [SB_W-1:0] side_b;

  ntt4_mulmod #(.W(W), .SIDE_W(SB_W)) u_mul_x3 (
    .clk, .rst_n, .m(modulus_r), .in_vld(va), .in_a(w2r), .in_b(side_a[W-1:0]),
    .in_side({side_a[SA_W-1 -: CNT_W], a0r, a1r, wr, iwr}),
    .out_vld(vb), .out_p(x3), .out_side(side_b));
  ntt4_mulmod #(.W(W), .SIDE_W(1)) u_mul_x2 (
    .clk, .rst_n, .m(modulus_r), .in_vld(va), .in_a(w2r), .in_b(side_a[2*W-1:W]),
    .in_side(1'b0), .out_vld(), .out_p(x2), .out_side());

  // Even and odd pair sums and differences.
  logic             vc_vld_r;
  logic [CNT_W-1:0] cnt_c_r;
  logic [W-1:0]     y0_r, y2_r, p_r, q_r, w_c_r, iw_c_r;
  logic [W-1:0]     b_a0, b_a1;

  assign b_a0 = side_b[4*W-1:3*W];
  assign b_a1 = side_b[3*W-1:2*W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_vld_r <= 1'b0;
    end else begin
      vc_vld_r <= vb;
    end
  end

  always_ff @(posedge clk) begin
    cnt_c_r <= side_b[SB_W-1 -: CNT_W];
    y0_r    <= mod_add(b_a0, x2, modulus_r);
    y2_r    <= mod_sub(b_a0, x2, modulus_r);
    p_r     <= mod_add(b_a1, x3, modulus_r);
    q_r     <= mod_sub(b_a1, x3, modulus_r);
    w_c_r   <= side_b[2*W-1:W];
    iw_c_r  <= side_b[W-1:0];
  end

  // w * (a1 + w^2 a3) and iw * (a1 - w^2 a3).
  localparam int SD_W = 2 * W + CNT_W;
  logic            vd;
  logic [W-1:0]    y1, y3;
  logic [SD_W-1:0] side_d;

  ntt4_mulmod #(.W(W), .SIDE_W(SD_W)) u_mul_y1 (
    .clk, .rst_n, .m(modulus_r), .in_vld(vc_vld_r), .in_a(w_c_r), .in_b(p_r),
    .in_side({cnt_c_r, y0_r, y2_r}), .out_vld(vd), .out_p(y1), .out_side(side_d));
  ntt4_mulmod #(.W(W), .SIDE_W(1)) u_mul_y3 (
    .clk, .rst_n, .m(modulus_r), .in_vld(vc_vld_r), .in_a(iw_c_r), .in_b(q_r),
    .in_side(1'b0), .out_vld(), .out_p(y3), .out_side());

  // Final butterfly, masking of unwanted results and the zero modulus case.
  logic             out_vld_r;
  ntt4_out_t        out_r;
  logic [CNT_W-1:0] d_cnt;
  logic [W-1:0]     d_y0, d_y2;
  logic             mz;

  assign d_cnt = side_d[SD_W-1 -: CNT_W];
  assign d_y0  = side_d[2*W-1:W];
  assign d_y2  = side_d[W-1:0];
  assign mz    = (modulus_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    out_r.valid_count <= d_cnt;
    out_r.b0 <= (!mz && d_cnt > 3'd0) ? mod_add(d_y0, y1, modulus_r) : '0;
    out_r.b1 <= (!mz && d_cnt > 3'd1) ? mod_sub(d_y0, y1, modulus_r) : '0;
    out_r.b2 <= (!mz && d_cnt > 3'd2) ? mod_add(d_y2, y3, modulus_r) : '0;
    out_r.b3 <= (!mz && d_cnt > 3'd3) ? mod_sub(d_y2, y3, modulus_r) : '0;
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.valid_count <= CNT_MAX)
    else $error("valid_count above four");

  a_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.valid_count <= CNT_R2) |-> (out_data.b2 == '0 && out_data.b3 == '0))
    else $error("result beyond valid_count not zero");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("request lost in the pipeline");

endmodule

[dv/tb.sv]
// Testbench for the modular radix-4/radix-2 NTT butterfly unit: directed and random requests,
// results predicted by an independent modular-arithmetic model and compared field by field.
// Depends on ntt4_pkg and ntt_radix4_butterfly_unit.
module tb
  import ntt4_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY  = 3 * RES_W + 2;
  localparam int WDOG_MAX = 20000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  ntt4_in_t         in_data;
  logic             out_strobe;
  ntt4_out_t        out_data;
  logic             cfg_we;
  logic [RES_W-1:0] cfg_wdata;

  ntt4_out_t        butterfly_q[$];
  logic [RES_W-1:0] cur_modulus;
  int               n_errors;
  int               n_reported;
  int               idle_cycles;
  bit               no_gaps;
  bit               timed_out;

  ntt_radix4_butterfly_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Modular arithmetic; products use 128-bit intermediates, so they never overflow.
  function automatic logic [RES_W-1:0] mulmod(logic [RES_W-1:0] a, logic [RES_W-1:0] b,
                                              logic [RES_W-1:0] m);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return RES_W'(p % 128'(m));
  endfunction

  function automatic logic [RES_W-1:0] addmod(logic [RES_W-1:0] a, logic [RES_W-1:0] b,
                                              logic [RES_W-1:0] m);
    return RES_W'((64'(a) + 64'(b)) % 64'(m));
  endfunction

  function automatic logic [RES_W-1:0] submod(logic [RES_W-1:0] a, logic [RES_W-1:0] b,
                                              logic [RES_W-1:0] m);
    return RES_W'((64'(a) + 64'(m) - 64'(b)) % 64'(m));
  endfunction

  function automatic ntt4_out_t butterfly(ntt4_in_t r, logic [RES_W-1:0] m);
    ntt4_out_t        o;
    logic [RES_W-1:0] a[4];
    logic [RES_W-1:0] b[4];
    logic [RES_W-1:0] w, w2, iw, x2, x3, y0, y1, y2, y3, t;
    int               icnt;
    int               lim;
    int               vc;
    icnt = (r.in_count > 4) ? 4 : int'(r.in_count);
    lim  = (r.op == OP_RADIX4) ? 4 : 2;
    vc   = (int'(r.out_count) > lim) ? lim : int'(r.out_count);
    for (int i = 0; i < 4; i++) b[i] = '0;
    if (m != 0) begin
      a[0] = (icnt > 0) ? r.a0 % m : '0;
      a[1] = (icnt > 1) ? r.a1 % m : '0;
      a[2] = (icnt > 2) ? r.a2 % m : '0;
      a[3] = (icnt > 3) ? r.a3 % m : '0;
      w  = r.tw_main % m;
      w2 = r.tw_square % m;
      iw = r.tw_imag % m;
      if (r.op == OP_RADIX4) begin
        x2 = mulmod(a[2], w2, m);
        x3 = mulmod(a[3], w2, m);
        y0 = addmod(a[0], x2, m);
        y1 = mulmod(addmod(a[1], x3, m), w, m);
        y2 = submod(a[0], x2, m);
        y3 = mulmod(submod(a[1], x3, m), iw, m);
        b[0] = addmod(y0, y1, m);
        b[1] = submod(y0, y1, m);
        b[2] = addmod(y2, y3, m);
        b[3] = submod(y2, y3, m);
      end else begin
        t = mulmod(a[1], w, m);
        b[0] = addmod(a[0], t, m);
        b[1] = submod(a[0], t, m);
      end
    end
    o.b0 = (vc > 0) ? b[0] : '0;
    o.b1 = (vc > 1) ? b[1] : '0;
    o.b2 = (vc > 2) ? b[2] : '0;
    o.b3 = (vc > 3) ? b[3] : '0;
    o.valid_count = CNT_W'(vc);
    return o;
  endfunction

  function automatic logic [RES_W-1:0] rand_res();
    return RES_W'({$urandom(), $urandom()});
  endfunction

  // Residue that is usually below the modulus but sometimes at or above it.
  function automatic logic [RES_W-1:0] rand_operand(logic [RES_W-1:0] m);
    logic [RES_W-1:0] v;
    v = rand_res();
    case ($urandom_range(0, 9))
      0: v = '1;
      1: v = m;
      2: v = (m == 0) ? '0 : m - 1;
      3: v = '0;
      4, 5: ;
      default: if (m != 0) v = v % m;
    endcase
    return v;
  endfunction

  function automatic ntt4_in_t rand_request(logic [RES_W-1:0] m);
    ntt4_in_t r;
    r.op        = 1'($urandom_range(0, 1));
    r.a0        = rand_operand(m);
    r.a1        = rand_operand(m);
    r.a2        = rand_operand(m);
    r.a3        = rand_operand(m);
    r.tw_main   = rand_operand(m);
    r.tw_square = rand_operand(m);
    r.tw_imag   = rand_operand(m);
    r.in_count  = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
    r.out_count = ($urandom_range(0, 3) != 0) ? 3'd4 : 3'($urandom_range(0, 7));
    return r;
  endfunction

  // Sends one request, with a random gap before it unless gaps are switched off.
  // start stays high afterwards so that the next request can follow directly.
  task automatic send_request(ntt4_in_t r);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    butterfly_q.push_back(butterfly(r, cur_modulus));
  endtask

  // Waits until every expected result has arrived, then lets the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (butterfly_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_modulus(logic [RES_W-1:0] m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_modulus = m;
  endtask

  task automatic test_directed();
    ntt4_in_t r;
    logic [RES_W-1:0] m;
    m = cur_modulus;
    for (int k = 0; k < 20; k++) begin
      r.op        = k[0] ? OP_RADIX4 : OP_RADIX2;
      r.a0        = (k < 4) ? '0 : (k < 8) ? m - 1 : (k < 12) ? '1 : rand_res();
      r.a1        = (k < 4) ? '0 : (k < 8) ? m - 1 : (k < 12) ? m : rand_res();
      r.a2        = (k < 8) ? m - 1 : '1;
      r.a3        = (k < 8) ? m - 1 : rand_res();
      r.tw_main   = (k < 6) ? 50'd1 : (k < 12) ? m - 1 : '1;
      r.tw_square = (k < 6) ? 50'd1 : m - 1;
      r.tw_imag   = (k < 10) ? m - 1 : '1;
      r.in_count  = 3'(k % 8);
      r.out_count = 3'((k + 3) % 8);
      send_request(r);
    end
  endtask

  task automatic test_random(int n);
    repeat (n) send_request(rand_request(cur_modulus));
  endtask

  task automatic test_back_to_back(int n);
    no_gaps = 1'b1;
    test_random(n);
    no_gaps = 1'b0;
  endtask

  task automatic test_odd_moduli();
    // Small, composite, unit and zero moduli still follow the formulas.
    write_modulus(50'd3);
    test_random(60);
    write_modulus(50'd1);
    test_random(20);
    write_modulus(50'd0);
    test_random(20);
    write_modulus(50'd12);
    test_random(40);
    write_modulus('1);
    test_directed();
    test_random(200);
  endtask

  // Checks each result against the oldest prediction.
  always @(posedge clk) begin
    ntt4_out_t exp_out;
    if (rst_n && out_strobe) begin
      if (butterfly_q.size() == 0) begin
        n_errors++;
        if (n_reported < 10) begin
          n_reported++;
          $display("ERROR: unexpected result %h", out_data);
        end
      end else begin
        exp_out = butterfly_q.pop_front();
        if (out_data.b0 !== exp_out.b0 || out_data.b1 !== exp_out.b1 ||
            out_data.b2 !== exp_out.b2 || out_data.b3 !== exp_out.b3 ||
            out_data.valid_count !== exp_out.valid_count) begin
          n_errors++;
          if (n_reported < 10) begin
            n_reported++;
            $display("ERROR: b0 %h/%h b1 %h/%h b2 %h/%h b3 %h/%h vc %0d/%0d (exp/act)",
                     exp_out.b0, out_data.b0, exp_out.b1, out_data.b1,
                     exp_out.b2, out_data.b2, exp_out.b3, out_data.b3,
                     exp_out.valid_count, out_data.valid_count);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no request and no result is taken.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        timed_out = 1'b1;
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    n_errors    = 0;
    n_reported  = 0;
    no_gaps     = 1'b0;
    timed_out   = 1'b0;
    cur_modulus = MODULUS_RST;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_back_to_back(300);
    write_modulus(50'd998244353);
    test_random(400);
    test_odd_moduli();
    write_modulus(50'd1125899906842597);
    test_random(300);
    test_back_to_back(100);
    drain();
    if (n_errors == 0 && butterfly_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
